// ===== design/eot_pkg.sv =====
// Package with shared types and constants for the edit operation transform block.
`timescale 1ns / 1ps

package eot_pkg;

   localparam int HISTORY_DEPTH = 64;
   localparam int POSITION_BITS = 16;
   localparam int COUNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   // Transaction function codes.
   localparam logic [1:0] FN_RECORD = 2'd0;
   localparam logic [1:0] FN_PRUNE_XFORM = 2'd1;
   localparam logic [1:0] FN_XFORM = 2'd2;

   // Result status codes.
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_DISCARD = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [1:0] func;
      logic is_insert;
      logic [31:0] edit_id;
      logic [31:0] prior_id;
      logic [7:0] origin_server;
      logic [15:0] position;
   } req_type;

   typedef struct packed {
      logic [15:0] adjusted_position;
      logic [31:0] new_prior_id;
      logic [1:0] status;
      logic [6:0] entries_held;
   } rsp_type;

   // One history entry.
   typedef struct packed {
      logic [31:0] id;
      logic [7:0] server;
      logic [POSITION_BITS-1:0] pos;
      logic ins;
   } entry_type;

   // The edit that travels down the chain of cells.
   typedef struct packed {
      logic vld;
      logic stop;
      logic ins;
      logic [31:0] id;
      logic [7:0] server;
      logic [POSITION_BITS-1:0] pos;
      logic [31:0] prior;
   } pkt_type;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic shift;
      logic load;
      logic active;
   } cell_ctl_type;

endpackage

// ===== design/edit_operation_transform_top.sv =====
// Top level of the edit operation transform block: sequencer and chain of history cells.
`timescale 1ns / 1ps

// A record transaction, or one with the unused function code, passes from
// acceptance through the finish state back to idle. A transform passes through
// the walk state, one with pruning first through the prune state; both end in
// the finish state. Pruning drops one entry from the front per cycle, then the
// edit travels the whole row of cells, one cell per cycle, whatever the number
// of entries held. One transaction is in work at a time; a finished result
// waits in the output register while the next transaction is accepted. The
// history holds no valid bits; cells past the entry count are skipped.
module edit_operation_transform_top import eot_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {S_IDLE, S_PRUNE, S_WALK, S_FINISH} state_type;

   state_type            state_ff;
   req_type              req_ff;
   logic [COUNT_W-1:0]   count_ff;
   rsp_type              res_ff;
   logic                 rsp_vld_ff;
   rsp_type              rsp_ff;
   logic                 inject_ff;

   entry_type    entries [HISTORY_DEPTH];
   entry_type    right_e [HISTORY_DEPTH];
   pkt_type      pkts [HISTORY_DEPTH+1];
   cell_ctl_type ctls [HISTORY_DEPTH];
   entry_type    new_entry;
   logic         accept, rec_we, shift_now, out_free;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free = !rsp_vld_ff || !rsp_stall;
   assign rec_we = accept && (req_data.func == FN_RECORD) && (count_ff < COUNT_W'(HISTORY_DEPTH));
   assign shift_now = (state_ff == S_PRUNE) && (count_ff != '0) &&
                      (entries[0].id <= req_ff.prior_id);

   assign new_entry = '{id: req_data.edit_id, server: req_data.origin_server,
                        pos: req_data.position, ins: req_data.is_insert};

   // Packet injected at the head of the chain when the walk begins, after pruning if any.
   always_comb begin
      pkts[0] = '{vld: inject_ff, stop: 1'b0, ins: req_ff.is_insert, id: req_ff.edit_id,
                  server: req_ff.origin_server, pos: req_ff.position,
                  prior: req_ff.prior_id};
   end

   // Row of history cells.
   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
      if (i == HISTORY_DEPTH - 1) begin : g_last
         assign right_e[i] = entries[i];
      end else begin : g_mid
         assign right_e[i] = entries[i+1];
      end
      assign ctls[i] = '{shift: shift_now, load: rec_we && (count_ff == COUNT_W'(i)),
                         active: COUNT_W'(i) < count_ff};
      eot_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctls[i]),
         .load_entry  (new_entry),
         .right_entry (right_e[i]),
         .entry       (entries[i]),
         .pkt_i       (pkts[i]),
         .pkt_o       (pkts[i+1])
      );
   end

   // Sequencer, entry count and output register.
   always_ff @(posedge clock) begin
      inject_ff <= 1'b0;
      if (out_free) begin
         rsp_vld_ff <= 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_ff <= req_data;
               res_ff <= '{adjusted_position: req_data.position,
                           new_prior_id: req_data.prior_id,
                           status: ((req_data.func == FN_RECORD) && !rec_we) ?
                                   ST_FULL : ST_OK,
                           entries_held: rec_we ? 7'(count_ff + 1'b1) : 7'(count_ff)};
               if (req_data.func == FN_RECORD) begin
                  if (rec_we) begin
                     count_ff <= count_ff + 1'b1;
                  end
                  state_ff <= S_FINISH;
               end else if (req_data.func == FN_PRUNE_XFORM) begin
                  state_ff <= S_PRUNE;
               end else if (req_data.func == FN_XFORM) begin
                  inject_ff <= 1'b1;
                  state_ff <= S_WALK;
               end else begin
                  state_ff <= S_FINISH;
               end
            end
         end
         S_PRUNE: begin
            if (shift_now) begin
               count_ff <= count_ff - 1'b1;
            end else begin
               inject_ff <= 1'b1;
               state_ff <= S_WALK;
            end
         end
         S_WALK: begin
            if (pkts[HISTORY_DEPTH].vld) begin
               res_ff <= '{adjusted_position: pkts[HISTORY_DEPTH].pos,
                           new_prior_id: pkts[HISTORY_DEPTH].prior,
                           status: pkts[HISTORY_DEPTH].stop ? ST_DISCARD : ST_OK,
                           entries_held: 7'(count_ff)};
               state_ff <= S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_vld_ff <= 1'b1;
               rsp_ff <= res_ff;
               state_ff <= S_IDLE;
            end
         end
         default: state_ff <= S_IDLE;
      endcase
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_vld_ff <= 1'b0;
         inject_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data = rsp_ff;

   // The entry count never exceeds the history depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(HISTORY_DEPTH))
      else $error("entry count above history depth");

   // A packet leaves the chain only while the sequencer waits for it.
   a_walk_exit: assert property (@(posedge clock) disable iff (reset)
      pkts[HISTORY_DEPTH].vld |-> (state_ff == S_WALK))
      else $error("walk result outside walk state");

   // A record into a full history leaves the count unchanged.
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.func == FN_RECORD) && (count_ff == COUNT_W'(HISTORY_DEPTH)))
      |=> (count_ff == COUNT_W'(HISTORY_DEPTH)))
      else $error("full history changed on record");

endmodule

// ===== design/eot_cell.sv =====
// One history cell: holds an entry and transforms the passing edit against it.
`timescale 1ns / 1ps

module eot_cell import eot_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  entry_type    load_entry,
   input  entry_type    right_entry,
   output entry_type    entry,
   input  pkt_type      pkt_i,
   output pkt_type      pkt_o
);

   entry_type entry_ff, entry_in;
   pkt_type   pkt_ff, pkt_in;
   logic      do_inc, do_dec, collide;

   // Entry storage: loaded on record, handed left during pruning.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.load) begin
         entry_in = load_entry;
      end else if (ctl.shift) begin
         entry_in = right_entry;
      end
   end

   // Insert and delete rules for this entry against the passing edit.
   always_comb begin
      do_inc = 1'b0;
      do_dec = 1'b0;
      collide = 1'b0;
      if (entry_ff.ins) begin
         if (pkt_i.ins) begin
            if (entry_ff.pos == pkt_i.pos) begin
               do_inc = (entry_ff.id > pkt_i.id) ||
                        ((entry_ff.id == pkt_i.id) && (entry_ff.server > pkt_i.server));
            end else begin
               do_inc = entry_ff.pos < pkt_i.pos;
            end
         end else begin
            do_inc = entry_ff.pos <= pkt_i.pos;
         end
      end else begin
         if (!pkt_i.ins && (entry_ff.pos == pkt_i.pos)) begin
            collide = 1'b1;
         end else begin
            do_dec = entry_ff.pos < pkt_i.pos;
         end
      end
   end

   always_comb begin
      pkt_in = pkt_i;
      if (pkt_i.vld && ctl.active && !pkt_i.stop) begin
         if (collide) begin
            pkt_in.stop = 1'b1;
         end else begin
            pkt_in.prior = entry_ff.id;
            if (do_inc && (pkt_i.pos != POS_MAX)) begin
               pkt_in.pos = pkt_i.pos + 1'b1;
            end else if (do_dec && (pkt_i.pos != '0)) begin
               pkt_in.pos = pkt_i.pos - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      pkt_ff <= pkt_in;
      if (reset) begin
         pkt_ff.vld <= 1'b0;
      end
   end

   assign entry = entry_ff;
   assign pkt_o = pkt_ff;

endmodule
